// ----- src/cv3_pkg.sv -----
// ----------------------------------------------------------------------------
// cv3_pkg
// Shared types, constants and helpers of the 3x3 convolution filter.
// ----------------------------------------------------------------------------
package cv3_pkg;

  localparam int PIXEL_BITS     = 8;
  localparam int COEF_BITS      = 5;
  localparam int TAPS           = 3;
  localparam int WIN_TAPS       = TAPS * TAPS;
  localparam int MAX_HEIGHT     = 1024;
  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int DIM_BITS       = 11;
  localparam int LEVEL_BITS     = 8;
  localparam int ROW_REG_BITS   = TAPS * COEF_BITS;
  localparam int CFG_DATA_BITS  = 15;
  localparam int CFG_INDEX_BITS = 3;
  localparam int ROW_BITS       = $clog2(MAX_HEIGHT + 2);
  localparam int PROD_BITS      = PIXEL_BITS + COEF_BITS + 1;
  localparam int SUM_BITS       = PROD_BITS + 4;
  localparam int MQ_DEPTH       = 4;
  localparam int MQ_COUNT_BITS  = $clog2(MQ_DEPTH + 1);
  localparam int OQ_DEPTH       = 4;
  localparam int OQ_COUNT_BITS  = $clog2(OQ_DEPTH + 1);

  // register indexes
  localparam logic [CFG_INDEX_BITS-1:0] REG_IMAGE_WIDTH  = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_IMAGE_HEIGHT = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_MAX_LEVEL    = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_COEF_TOP     = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] REG_COEF_MID     = 3'd4;
  localparam logic [CFG_INDEX_BITS-1:0] REG_COEF_BOTTOM  = 3'd5;

  localparam logic [DIM_BITS-1:0]   WIDTH_RST  = 11'd640;
  localparam logic [DIM_BITS-1:0]   HEIGHT_RST = 11'd480;
  localparam logic [LEVEL_BITS-1:0] LEVEL_RST  = 8'd255;

  typedef struct packed {
    logic [PIXEL_BITS-1:0] pixel_in;
    logic                  flush;
  } pix_in_t;

  typedef struct packed {
    logic [PIXEL_BITS-1:0] pixel_out;
    logic                  frame_last;
  } pix_out_t;

  typedef struct packed {
    logic [DIM_BITS-1:0]                image_width;
    logic [DIM_BITS-1:0]                image_height;
    logic [LEVEL_BITS-1:0]              max_level;
    logic [TAPS-1:0][ROW_REG_BITS-1:0]  coef_row;   // index 0 is the top row
  } cfg_t;

  // one neighbourhood, row-major from top left, plus what the back end needs
  typedef struct packed {
    logic [WIN_TAPS-1:0][PIXEL_BITS-1:0] pix;
    logic                                border;
    logic                                last;
  } win_t;

  function automatic logic signed [COEF_BITS-1:0] coef_at(
    input logic [ROW_REG_BITS-1:0] row,
    input int                      pos
  );
    return row[pos*COEF_BITS +: COEF_BITS];
  endfunction

endpackage

// ----- src/cv3_ram.sv -----
// ----------------------------------------------------------------------------
// cv3_ram
// Simple dual-port RAM, one write and one registered read port, read-first.
// ----------------------------------------------------------------------------
module cv3_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- src/cv3_fifo.sv -----
// ----------------------------------------------------------------------------
// cv3_fifo
// Small register queue with occupancy count.
// ----------------------------------------------------------------------------
module cv3_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  input  logic [WIDTH-1:0]           wdata,
  input  logic                       pop,
  output logic [WIDTH-1:0]           rdata,
  output logic                       empty,
  output logic [$clog2(DEPTH+1)-1:0] count
);

  localparam int PB = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CB = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PB-1:0]    wr_ptr, rd_ptr;
  logic [PB-1:0]    wr_ptr_next, rd_ptr_next;
  logic [CB-1:0]    count_next;
  logic             do_pop;

  assign empty  = (count == '0);
  assign do_pop = pop && !empty;
  assign rdata  = mem[rd_ptr];

  always_comb begin
    wr_ptr_next = wr_ptr;
    rd_ptr_next = rd_ptr;
    count_next  = count;
    if (push) begin
      wr_ptr_next = (wr_ptr == PB'(DEPTH - 1)) ? '0 : wr_ptr + PB'(1);
    end
    if (do_pop) begin
      rd_ptr_next = (rd_ptr == PB'(DEPTH - 1)) ? '0 : rd_ptr + PB'(1);
    end
    if (push && !do_pop) begin
      count_next = count + CB'(1);
    end else if (do_pop && !push) begin
      count_next = count - CB'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr_next;
      rd_ptr <= rd_ptr_next;
      count  <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wdata;
    end
  end

endmodule

// ----- src/cv3_front.sv -----
// ----------------------------------------------------------------------------
// cv3_front
// Frame position tracking, line buffers and 3x3 window; classifies each
// transaction and queues the neighbourhood of every pixel that is due.
// ----------------------------------------------------------------------------
module cv3_front #(
  parameter int MAX_WIDTH = cv3_pkg::MAX_WIDTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  cv3_pkg::cfg_t                      cfg,
  input  logic                               push,
  input  cv3_pkg::pix_in_t                   in_item,
  output logic                               full,
  output logic                               win_push,
  output cv3_pkg::win_t                      win_data,
  input  logic [cv3_pkg::MQ_COUNT_BITS-1:0]  win_count
);

  import cv3_pkg::*;

  localparam int WB   = $clog2(MAX_WIDTH + 1);
  localparam int AB   = $clog2(MAX_WIDTH);
  localparam int CMPW = (WB > DIM_BITS) ? WB : DIM_BITS;
  localparam int HB   = $clog2(MAX_HEIGHT + 1);
  localparam int IB   = $clog2(MAX_HEIGHT * MAX_WIDTH + 2 * MAX_WIDTH + 2);

  logic [WB-1:0] w_c;
  logic [HB-1:0] h_c;

  // frame position
  logic [IB-1:0]       in_index, in_index_next;
  logic [IB-1:0]       out_index, out_index_next;
  logic [WB-1:0]       in_col, in_col_next;
  logic [ROW_BITS-1:0] in_row, in_row_next;
  logic [WB-1:0]       out_col, out_col_next;
  logic [ROW_BITS-1:0] out_row, out_row_next;

  logic                  accept, in_ge, in_ge_w, in_small, bad, ignore, produce;
  logic [IB-1:0]         w_ext, k;
  logic [WB-1:0]         col;
  logic [ROW_BITS-1:0]   row;
  logic [PIXEL_BITS-1:0] v;
  logic                  border, last;

  // stage after the line buffer read
  logic                  s1_valid, s1_out, s1_border, s1_last;
  logic [AB-1:0]         s1_col;
  logic [PIXEL_BITS-1:0] s1_v;
  logic                  fwd;
  logic [PIXEL_BITS-1:0] fwd_top, fwd_mid;
  logic [PIXEL_BITS-1:0] top_rdata, mid_rdata, top1, mid1;

  logic [WIN_TAPS-1:0][PIXEL_BITS-1:0] win, win_n;

  always_comb begin
    if (cfg.image_width < DIM_BITS'(3)) begin
      w_c = WB'(3);
    end else if (CMPW'(cfg.image_width) > CMPW'(MAX_WIDTH)) begin
      w_c = WB'(MAX_WIDTH);
    end else begin
      w_c = WB'(cfg.image_width);
    end
    if (cfg.image_height < DIM_BITS'(3)) begin
      h_c = HB'(3);
    end else if (cfg.image_height > DIM_BITS'(MAX_HEIGHT)) begin
      h_c = HB'(MAX_HEIGHT);
    end else begin
      h_c = HB'(cfg.image_height);
    end
  end

  // one slot is kept for the transaction still in the read stage
  assign full   = (win_count >= MQ_COUNT_BITS'(MQ_DEPTH - 1));
  assign accept = push && !full;

  assign w_ext    = IB'(w_c);
  assign in_ge    = (in_index > w_ext);
  assign in_ge_w  = (in_index >= w_ext);
  assign in_small = !in_ge || (in_index == w_ext + IB'(1));

  // counters out of step after a size change restart the frame
  assign bad = (in_ge ? (out_index + w_ext + IB'(1) != in_index) : (out_index != '0))
               || (out_row >= ROW_BITS'(h_c));
  assign ignore  = in_item.flush && (bad || (in_index == '0));
  assign produce = !bad && in_ge;
  assign k       = bad ? '0 : in_index;

  // column and row of the incoming pixel; near the frame start they are
  // derived from the index so that a width change is picked up
  always_comb begin
    if (bad) begin
      col = '0;
      row = '0;
    end else if (in_small) begin
      if (in_ge_w) begin
        col = WB'(in_index - w_ext);
        row = ROW_BITS'(1);
      end else begin
        col = WB'(in_index);
        row = '0;
      end
    end else begin
      col = in_col;
      row = in_row;
    end
  end

  // flush items and pixels past the frame enter the line buffers as zero
  assign v = (in_item.flush || (row >= ROW_BITS'(h_c))) ? '0 : in_item.pixel_in;

  assign last   = (out_row == ROW_BITS'(h_c - HB'(1))) && (out_col == w_c - WB'(1));
  assign border = (out_row == '0) || (out_row == ROW_BITS'(h_c - HB'(1)))
                  || (out_col == '0) || (out_col == w_c - WB'(1));

  always_comb begin
    in_index_next  = in_index;
    out_index_next = out_index;
    in_col_next    = in_col;
    in_row_next    = in_row;
    out_col_next   = out_col;
    out_row_next   = out_row;
    if (accept) begin
      if (ignore || (produce && last)) begin
        in_index_next  = '0;
        out_index_next = '0;
        in_col_next    = '0;
        in_row_next    = '0;
        out_col_next   = '0;
        out_row_next   = '0;
      end else begin
        in_index_next = k + IB'(1);
        if (col == w_c - WB'(1)) begin
          in_col_next = '0;
          in_row_next = row + ROW_BITS'(1);
        end else begin
          in_col_next = col + WB'(1);
          in_row_next = row;
        end
        if (bad) begin
          out_index_next = '0;
          out_col_next   = '0;
          out_row_next   = '0;
        end else if (produce) begin
          out_index_next = out_index + IB'(1);
          if (out_col == w_c - WB'(1)) begin
            out_col_next = '0;
            out_row_next = out_row + ROW_BITS'(1);
          end else begin
            out_col_next = out_col + WB'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_index  <= '0;
      out_index <= '0;
      in_col    <= '0;
      in_row    <= '0;
      out_col   <= '0;
      out_row   <= '0;
      s1_valid  <= 1'b0;
    end else begin
      in_index  <= in_index_next;
      out_index <= out_index_next;
      in_col    <= in_col_next;
      in_row    <= in_row_next;
      out_col   <= out_col_next;
      out_row   <= out_row_next;
      s1_valid  <= accept && !ignore;
    end
  end

  // the column written by the previous transaction may be read again at once
  // (frame end meets frame start at column zero), so its data is forwarded
  always_ff @(posedge clk) begin
    if (accept && !ignore) begin
      s1_out    <= produce;
      s1_border <= border;
      s1_last   <= last;
      s1_col    <= col[AB-1:0];
      s1_v      <= v;
      fwd       <= s1_valid && (s1_col == col[AB-1:0]);
      fwd_top   <= mid1;
      fwd_mid   <= s1_v;
    end
  end

  // line contents are not cleared at reset: every neighbour that reaches a
  // filtered result was written earlier in the same frame
  cv3_ram #(
    .WIDTH (PIXEL_BITS),
    .DEPTH (MAX_WIDTH)
  ) u_top_line (
    .clk   (clk),
    .we    (s1_valid),
    .waddr (s1_col),
    .wdata (mid1),
    .re    (accept && !ignore),
    .raddr (col[AB-1:0]),
    .rdata (top_rdata)
  );

  cv3_ram #(
    .WIDTH (PIXEL_BITS),
    .DEPTH (MAX_WIDTH)
  ) u_mid_line (
    .clk   (clk),
    .we    (s1_valid),
    .waddr (s1_col),
    .wdata (s1_v),
    .re    (accept && !ignore),
    .raddr (col[AB-1:0]),
    .rdata (mid_rdata)
  );

  assign top1 = fwd ? fwd_top : top_rdata;
  assign mid1 = fwd ? fwd_mid : mid_rdata;

  always_comb begin
    win_n[0] = win[1];
    win_n[1] = win[2];
    win_n[2] = top1;
    win_n[3] = win[4];
    win_n[4] = win[5];
    win_n[5] = mid1;
    win_n[6] = win[7];
    win_n[7] = win[8];
    win_n[8] = s1_v;
  end

  always_ff @(posedge clk) begin
    if (s1_valid) begin
      win <= win_n;
    end
  end

  assign win_push        = s1_valid && s1_out;
  assign win_data.pix    = win_n;
  assign win_data.border = s1_border;
  assign win_data.last   = s1_last;

endmodule

// ----- src/cv3_back.sv -----
// ----------------------------------------------------------------------------
// cv3_back
// Kernel arithmetic: nine products, sum, magnitude and clamp, or the center
// pixel unchanged on a border.
// ----------------------------------------------------------------------------
module cv3_back (
  input  logic                               clk,
  input  logic                               rst,
  input  cv3_pkg::cfg_t                      cfg,
  input  logic                               win_empty,
  input  cv3_pkg::win_t                      win_data,
  output logic                               win_pop,
  input  logic [cv3_pkg::OQ_COUNT_BITS-1:0]  out_count,
  output logic                               out_push,
  output cv3_pkg::pix_out_t                  out_data
);

  import cv3_pkg::*;

  localparam int CENTER = 4;

  logic                        a_valid, a_border, a_last;
  logic [PIXEL_BITS-1:0]       a_center;
  logic signed [PROD_BITS-1:0] a_prod [WIN_TAPS];

  logic                        b_valid, b_border, b_last;
  logic [PIXEL_BITS-1:0]       b_center;
  logic signed [SUM_BITS-1:0]  b_sum, sum;
  logic [SUM_BITS-1:0]         mag;
  logic [OQ_COUNT_BITS:0]      in_flight;

  // room in the result queue for everything already in the pipeline
  assign in_flight = {1'b0, out_count} + (OQ_COUNT_BITS+1)'(a_valid)
                     + (OQ_COUNT_BITS+1)'(b_valid);
  assign win_pop   = !win_empty && (in_flight < (OQ_COUNT_BITS+1)'(OQ_DEPTH));

  for (genvar i = 0; i < WIN_TAPS; i++) begin : g_tap
    always_ff @(posedge clk) begin
      if (win_pop) begin
        a_prod[i] <= coef_at(cfg.coef_row[i / TAPS], i % TAPS)
                     * $signed({1'b0, win_data.pix[i]});
      end
    end
  end

  always_ff @(posedge clk) begin
    if (win_pop) begin
      a_border <= win_data.border;
      a_last   <= win_data.last;
      a_center <= win_data.pix[CENTER];
    end
  end

  always_comb begin
    sum = '0;
    for (int i = 0; i < WIN_TAPS; i++) begin
      sum = sum + SUM_BITS'(a_prod[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (a_valid) begin
      b_sum    <= sum;
      b_border <= a_border;
      b_last   <= a_last;
      b_center <= a_center;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
    end else begin
      a_valid <= win_pop;
      b_valid <= a_valid;
    end
  end

  assign mag = b_sum[SUM_BITS-1] ? SUM_BITS'(-b_sum) : SUM_BITS'(b_sum);

  always_comb begin
    if (b_border) begin
      out_data.pixel_out = b_center;
    end else if (mag > SUM_BITS'(cfg.max_level)) begin
      out_data.pixel_out = cfg.max_level;
    end else begin
      out_data.pixel_out = mag[PIXEL_BITS-1:0];
    end
    out_data.frame_last = b_last;
  end

  assign out_push = b_valid;

endmodule

// ----- src/convolution_3x3_abs_clamp.sv -----
// ----------------------------------------------------------------------------
// convolution_3x3_abs_clamp
// Streaming 3x3 kernel filter with magnitude and clamp, border pass-through.
// ----------------------------------------------------------------------------
// Usage:
//   Pixels enter in raster order through push/full; a transaction is taken
//   when push is high and full is low. Results leave through empty/pop, the
//   oldest one shown while empty is low and taken when pop is high.
//   The result for raster index k-(width+1) is caused by input k, so
//   width+1 flush items after a frame drain it; frame_last marks the final
//   pixel. Throughput is one pixel per cycle while full is low: each line
//   buffer does one read and one write per cycle, the write landing in the
//   cycle after the read, with a forward path when the same column comes
//   back at once. Results pass the window queue and then the result queue.
//   Configuration writes take effect at once and belong to idle periods.
//   Reset clears counters, pipeline and queues; the line buffers are not
//   cleared and need no clearing pass. When the receiver stalls, results
//   collect in a four-entry result queue, then in a four-entry window queue;
//   full goes high once that window queue holds three entries.
// ----------------------------------------------------------------------------
module convolution_3x3_abs_clamp #(
  parameter int MAX_WIDTH = cv3_pkg::MAX_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                push,
  output logic                                full,
  input  cv3_pkg::pix_in_t                    in_item,
  output logic                                empty,
  input  logic                                pop,
  output cv3_pkg::pix_out_t                   out_item,
  input  logic                                cfg_wr_en,
  input  logic [cv3_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [cv3_pkg::CFG_DATA_BITS-1:0]   cfg_data
);

  import cv3_pkg::*;

  cfg_t                     cfg;
  logic                     win_push, win_pop, win_empty, out_push;
  win_t                     win_wdata;
  logic [$bits(win_t)-1:0]  win_rdata;
  logic [MQ_COUNT_BITS-1:0] win_count;
  pix_out_t                 out_wdata;
  logic [$bits(pix_out_t)-1:0] out_rdata;
  logic [OQ_COUNT_BITS-1:0] out_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.image_width  <= WIDTH_RST;
      cfg.image_height <= HEIGHT_RST;
      cfg.max_level    <= LEVEL_RST;
      cfg.coef_row     <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_IMAGE_WIDTH:  cfg.image_width  <= cfg_data[DIM_BITS-1:0];
        REG_IMAGE_HEIGHT: cfg.image_height <= cfg_data[DIM_BITS-1:0];
        REG_MAX_LEVEL:    cfg.max_level    <= cfg_data[LEVEL_BITS-1:0];
        REG_COEF_TOP:     cfg.coef_row[0]  <= cfg_data[ROW_REG_BITS-1:0];
        REG_COEF_MID:     cfg.coef_row[1]  <= cfg_data[ROW_REG_BITS-1:0];
        REG_COEF_BOTTOM:  cfg.coef_row[2]  <= cfg_data[ROW_REG_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  cv3_front #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .push      (push),
    .in_item   (in_item),
    .full      (full),
    .win_push  (win_push),
    .win_data  (win_wdata),
    .win_count (win_count)
  );

  cv3_fifo #(
    .WIDTH ($bits(win_t)),
    .DEPTH (MQ_DEPTH)
  ) u_win_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (win_push),
    .wdata (win_wdata),
    .pop   (win_pop),
    .rdata (win_rdata),
    .empty (win_empty),
    .count (win_count)
  );

  cv3_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .win_empty (win_empty),
    .win_data  (win_t'(win_rdata)),
    .win_pop   (win_pop),
    .out_count (out_count),
    .out_push  (out_push),
    .out_data  (out_wdata)
  );

  cv3_fifo #(
    .WIDTH ($bits(pix_out_t)),
    .DEPTH (OQ_DEPTH)
  ) u_out_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (out_push),
    .wdata (out_wdata),
    .pop   (pop),
    .rdata (out_rdata),
    .empty (empty),
    .count (out_count)
  );

  assign out_item = pix_out_t'(out_rdata);

endmodule

// ----- src/cv3_checker.sv -----
// ----------------------------------------------------------------------------
// cv3_checker
// Port-level properties of the convolution filter, bound to the top level.
// ----------------------------------------------------------------------------
module cv3_checker (
  input logic              clk,
  input logic              rst,
  input logic              push,
  input logic              full,
  input logic              empty,
  input logic              pop,
  input cv3_pkg::pix_out_t out_item
);

  import cv3_pkg::*;

  // the queues and pipeline start empty, so nothing can show right after reset
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> empty ##1 empty ##1 empty ##1 empty)
    else $error("result shown too soon after reset");

  a_reset_ready: assert property (@(posedge clk)
    rst |=> !full)
    else $error("full high after reset");

  // back-pressure only builds up behind an accepted transaction, once it has
  // left the line buffer read stage and been counted in the window queue
  a_full_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(full) |-> $past(push && !full, 2))
    else $error("full rose without an accepted transaction");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    !empty && !pop |=> !empty && $stable(out_item))
    else $error("stalled result changed");

endmodule

bind convolution_3x3_abs_clamp cv3_checker u_cv3_checker (
  .clk      (clk),
  .rst      (rst),
  .push     (push),
  .full     (full),
  .empty    (empty),
  .pop      (pop),
  .out_item (out_item)
);

// ----- dv/convolution_3x3_abs_clamp_tb.sv -----
// ----------------------------------------------------------------------------
// convolution_3x3_abs_clamp_tb
// Drives pixel frames through the 3x3 filter with random bursts and result
// stalls, predicts output pixels with a behavioral copy of the filter or typed
// values and compares each popped transaction field by field.
// ----------------------------------------------------------------------------
module convolution_3x3_abs_clamp_tb;
  import cv3_pkg::*;

  localparam int MAX_W        = MAX_WIDTH_DEF;
  localparam int RANDOM_ITEMS = 220;
  localparam int DRAIN_CYCLES = 12;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int PRINT_LIMIT  = 40;
  localparam int PLAN_ROWS    = 28;
  localparam int WIDE_TAIL    = 9;

  // weights packed three to a row register
  localparam logic [14:0] COEF_ALL_MIN = 15'h4210;
  localparam logic [14:0] COEF_ALL_MAX = 15'h3DEF;
  localparam logic [14:0] COEF_ALL_NEG1 = 15'h7FFF;

  typedef enum logic [1:0] {EXP_NONE, EXP_TYPED, EXP_MODEL} exp_kind_e;
  typedef enum logic [1:0] {POP_ALWAYS, POP_COIN, POP_SPARSE, POP_HOLD} pop_mode_e;

  typedef struct packed {
    logic [7:0] pix;
    logic       flush;
    exp_kind_e  kind;
    logic [7:0] want_pix;
    logic       want_last;
  } plan_row_t;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      push = 1'b0;
  logic                      full;
  pix_in_t                   in_item = '0;
  logic                      empty;
  logic                      pop = 1'b0;
  pix_out_t                  out_item;
  logic                      cfg_wr_en = 1'b0;
  logic [CFG_INDEX_BITS-1:0] cfg_index = REG_IMAGE_WIDTH;
  logic [CFG_DATA_BITS-1:0]  cfg_data = '0;

  convolution_3x3_abs_clamp dut (
    .clk(clk), .rst(rst), .push(push), .full(full), .in_item(in_item),
    .empty(empty), .pop(pop), .out_item(out_item),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // filter state as the predictor sees it
  logic [DIM_BITS-1:0]     set_width;
  logic [DIM_BITS-1:0]     set_height;
  logic [LEVEL_BITS-1:0]   set_level;
  logic [ROW_REG_BITS-1:0] set_coef [3];
  logic [7:0]              mid_line [MAX_W];
  logic [7:0]              top_line [MAX_W];
  logic [7:0]              win [3][3];
  int unsigned             in_count, out_count;
  bit                      was_ignored;

  pix_out_t pending_pixels [$];
  int       errors = 0;
  int       cycles = 0;
  int       random_items = 0;
  int       burst_left = 0;
  bit       calm = 1'b0;
  int       pop_left = 0;
  pop_mode_e pop_mode = POP_ALWAYS;

  // 3x3 frames, all weights -16, ceiling 255
  plan_row_t plan [PLAN_ROWS] = '{
    '{8'h00, 1'b1, EXP_NONE,  8'h00, 1'b0},  // flush with no frame open
    '{8'h00, 1'b0, EXP_NONE,  8'h00, 1'b0},
    '{8'hFF, 1'b0, EXP_NONE,  8'h00, 1'b0},
    '{8'h80, 1'b0, EXP_NONE,  8'h00, 1'b0},
    '{8'h01, 1'b0, EXP_NONE,  8'h00, 1'b0},
    '{8'hAA, 1'b0, EXP_TYPED, 8'h00, 1'b0},
    '{8'hC3, 1'b1, EXP_TYPED, 8'hFF, 1'b0},  // flush inside the frame
    '{8'h55, 1'b0, EXP_TYPED, 8'h80, 1'b0},
    '{8'h7F, 1'b0, EXP_TYPED, 8'h01, 1'b0},
    '{8'hFE, 1'b0, EXP_TYPED, 8'hFF, 1'b0},  // interior saturates
    '{8'h33, 1'b0, EXP_TYPED, 8'h00, 1'b0},  // pixel past the frame end
    '{8'h5A, 1'b1, EXP_TYPED, 8'h55, 1'b0},
    '{8'h00, 1'b1, EXP_TYPED, 8'h7F, 1'b0},
    '{8'h00, 1'b1, EXP_TYPED, 8'hFE, 1'b1},
    '{8'h99, 1'b1, EXP_NONE,  8'h00, 1'b0},
    '{8'h08, 1'b0, EXP_NONE,  8'h00, 1'b0},
    '{8'h00, 1'b0, EXP_NONE,  8'h00, 1'b0},
    '{8'h00, 1'b0, EXP_NONE,  8'h00, 1'b0},
    '{8'h00, 1'b0, EXP_NONE,  8'h00, 1'b0},
    '{8'h01, 1'b0, EXP_MODEL, 8'h00, 1'b0},
    '{8'h00, 1'b0, EXP_MODEL, 8'h00, 1'b0},
    '{8'h00, 1'b0, EXP_MODEL, 8'h00, 1'b0},
    '{8'h00, 1'b0, EXP_MODEL, 8'h00, 1'b0},
    '{8'h02, 1'b0, EXP_MODEL, 8'h00, 1'b0},
    '{8'h00, 1'b1, EXP_MODEL, 8'h00, 1'b0},
    '{8'h00, 1'b1, EXP_MODEL, 8'h00, 1'b0},
    '{8'h00, 1'b1, EXP_MODEL, 8'h00, 1'b0},
    '{8'h00, 1'b1, EXP_MODEL, 8'h00, 1'b0}
  };

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic pix_in_t make_item(input int pix, input bit fl);
    pix_in_t it;
    it.pixel_in = pix[7:0];
    it.flush    = fl;
    return it;
  endfunction

  // one input transaction through the filter; returns 1 when a pixel comes out
  function automatic bit filter_step(input pix_in_t it, output pix_out_t res);
    int unsigned w, h, n, due, k, col, orow, ocol, mag;
    logic [7:0]  v, up, mid_px;
    logic signed [COEF_BITS-1:0] wt;
    int          sum;
    res = '0;
    w = (set_width < 3) ? 3 : ((set_width > MAX_W) ? MAX_W : set_width);
    h = (set_height < 3) ? 3 : ((set_height > MAX_HEIGHT) ? MAX_HEIGHT : set_height);
    n = w * h;
    due = (in_count >= w + 1) ? in_count - w - 1 : 0;
    // counters out of step with the geometry: start over with this item
    if (out_count != due || out_count >= n) begin
      in_count  = 0;
      out_count = 0;
    end
    was_ignored = it.flush && in_count == 0;
    if (was_ignored) return 1'b0;
    v = (it.flush || in_count >= n) ? 8'h00 : it.pixel_in;
    k = in_count;
    col = k % w;
    up = top_line[col];
    mid_px = mid_line[col];
    top_line[col] = mid_px;
    mid_line[col] = v;
    for (int r = 0; r < 3; r++) begin
      win[r][0] = win[r][1];
      win[r][1] = win[r][2];
    end
    win[0][2] = up;
    win[1][2] = mid_px;
    win[2][2] = v;
    in_count = k + 1;
    if (k < w + 1) return 1'b0;
    orow = out_count / w;
    ocol = out_count % w;
    if (orow == 0 || orow == h - 1 || ocol == 0 || ocol == w - 1) begin
      res.pixel_out = win[1][1];
    end else begin
      sum = 0;
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          wt = set_coef[r][c*COEF_BITS +: COEF_BITS];
          sum += int'(wt) * int'(win[r][c]);
        end
      end
      mag = (sum < 0) ? -sum : sum;
      res.pixel_out = (mag > set_level) ? set_level : mag[7:0];
    end
    res.frame_last = (out_count == n - 1);
    out_count++;
    if (res.frame_last) begin
      in_count  = 0;
      out_count = 0;
    end
    return 1'b1;
  endfunction

  task automatic report(input string what);
    errors++;
    if (errors <= PRINT_LIMIT) $display("mismatch at cycle %0d: %s", cycles, what);
  endtask

  task automatic feed(input pix_in_t it, input exp_kind_e kind = EXP_MODEL,
                      input pix_out_t typed = '0);
    pix_out_t res;
    bit       got;
    in_item <= it;
    push <= 1'b1;
    @(posedge clk);
    while (full) @(posedge clk);
    got = filter_step(it, res);
    if (!was_ignored) random_items++;
    if (kind == EXP_TYPED) pending_pixels.push_back(typed);
    else if (kind == EXP_MODEL && got) pending_pixels.push_back(res);
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if (!calm) begin
        push <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
  endtask

  task automatic settle();
    push <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] data);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    case (idx)
      REG_IMAGE_WIDTH:  set_width   = data[DIM_BITS-1:0];
      REG_IMAGE_HEIGHT: set_height  = data[DIM_BITS-1:0];
      REG_MAX_LEVEL:    set_level   = data[LEVEL_BITS-1:0];
      REG_COEF_TOP:     set_coef[0] = data;
      REG_COEF_MID:     set_coef[1] = data;
      REG_COEF_BOTTOM:  set_coef[2] = data;
      default: ;
    endcase
  endtask

  task automatic load_settings(input logic [14:0] w, h, lvl, top, mid, bot);
    write_reg(REG_IMAGE_WIDTH, w);
    write_reg(REG_IMAGE_HEIGHT, h);
    write_reg(REG_MAX_LEVEL, lvl);
    write_reg(REG_COEF_TOP, top);
    write_reg(REG_COEF_MID, mid);
    write_reg(REG_COEF_BOTTOM, bot);
    cfg_wr_en <= 1'b0;
  endtask

  function automatic logic [14:0] pick_coef();
    case ($urandom_range(0, 7))
      0:       return COEF_ALL_MIN;
      1:       return COEF_ALL_MAX;
      2:       return COEF_ALL_NEG1;
      3:       return 15'd0;
      default: return 15'($urandom_range(0, 32767));
    endcase
  endfunction

  function automatic logic [14:0] pick_level();
    case ($urandom_range(0, 5))
      0:       return 15'd0;
      1:       return 15'd255;
      2:       return 15'd1;
      default: return 15'($urandom_range(0, 255));
    endcase
  endfunction

  // result side: stall pattern of its own, a random pop mode held for each run
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop_left == 0) begin
        pop_mode = pop_mode_e'($urandom_range(0, 3));
        pop_left = $urandom_range(8, 80);
      end
      pop_left--;
      case (pop_mode)
        POP_ALWAYS: pop <= 1'b1;
        POP_COIN:   pop <= 1'($urandom_range(0, 1));
        POP_SPARSE: pop <= ($urandom_range(0, 5) == 0);
        default:    pop <= 1'b0;
      endcase
    end
  end

  always @(posedge clk) begin : check_results
    pix_out_t want;
    if (!rst && pop && !empty) begin
      if (pending_pixels.size() == 0) begin
        report("output transaction with nothing outstanding");
      end else begin
        want = pending_pixels.pop_front();
        if (out_item.pixel_out !== want.pixel_out)
          report($sformatf("pixel_out %h, expected %h", out_item.pixel_out, want.pixel_out));
        if (out_item.frame_last !== want.frame_last)
          report($sformatf("frame_last %b, expected %b", out_item.frame_last,
                           want.frame_last));
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("[convolution_3x3_abs_clamp] ERROR");
      $finish;
    end
  end

  initial begin
    int unsigned fw, fh, fn, cut, nf;
    logic [14:0] raw_w, raw_h;
    bit          small_px, cut_short;
    pix_out_t    typed;

    set_width  = WIDTH_RST;
    set_height = HEIGHT_RST;
    set_level  = LEVEL_RST;
    for (int r = 0; r < 3; r++) set_coef[r] = '0;
    for (int i = 0; i < MAX_W; i++) begin
      mid_line[i] = '0;
      top_line[i] = '0;
    end
    for (int r = 0; r < 3; r++)
      for (int c = 0; c < 3; c++) win[r][c] = '0;
    in_count  = 0;
    out_count = 0;

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed frames
    load_settings(15'd3, 15'd3, 15'd255, COEF_ALL_MIN, COEF_ALL_MIN, COEF_ALL_MIN);
    for (int i = 0; i < PLAN_ROWS; i++) begin
      typed.pixel_out  = plan[i].want_pix;
      typed.frame_last = plan[i].want_last;
      feed(make_item(plan[i].pix, plan[i].flush), plan[i].kind, typed);
    end
    settle();

    // widest line: first row and a few results, left open for the next settings
    load_settings(15'd2047, 15'd0, pick_level(), pick_coef(), pick_coef(), pick_coef());
    for (int i = 0; i < MAX_W + 1 + WIDE_TAIL; i++)
      feed(make_item($urandom_range(0, 255), $urandom_range(0, 31) == 0));
    settle();

    // tallest frame, left open so the next settings break it off
    load_settings(15'd1, 15'd2047, pick_level(), pick_coef(), pick_coef(), pick_coef());
    for (int i = 0; i < 40; i++) feed(make_item($urandom_range(0, 255), 1'b0));

    random_items = 0;
    while (random_items < RANDOM_ITEMS) begin
      settle();
      case ($urandom_range(0, 19))
        0:       raw_w = 15'($urandom_range(0, 2));
        1:       raw_w = 15'($urandom_range(13, 40));
        default: raw_w = 15'($urandom_range(3, 8));
      endcase
      case ($urandom_range(0, 19))
        0:       raw_h = 15'($urandom_range(0, 2));
        1:       raw_h = 15'($urandom_range(9, 16));
        default: raw_h = 15'($urandom_range(3, 6));
      endcase
      load_settings(raw_w, raw_h, pick_level(), pick_coef(), pick_coef(), pick_coef());
      fw = (raw_w < 3) ? 3 : raw_w;
      fh = (raw_h < 3) ? 3 : raw_h;
      fn = fw * fh;
      calm = ($urandom_range(0, 4) == 0);
      small_px = ($urandom_range(0, 2) == 0);

      if ($urandom_range(0, 4) == 0) begin
        // noise: pixels and flushes in no particular order
        repeat ($urandom_range(10, 60))
          feed(make_item($urandom_range(0, 255), $urandom_range(0, 9) < 3));
      end else begin
        nf = $urandom_range(1, 3);
        cut_short = 1'b0;
        for (int f = 0; f < nf && !cut_short; f++) begin
          cut = ($urandom_range(0, 6) == 0) ? $urandom_range(1, fn + fw) : fn + fw + 1;
          for (int i = 0; i < fn + fw + 1 && !cut_short; i++) begin
            if (i == cut) begin
              cut_short = 1'b1;
            end else if (i < fn) begin
              feed(make_item(small_px ? $urandom_range(0, 15) : $urandom_range(0, 255),
                             $urandom_range(0, 24) == 0));
            end else begin
              feed(make_item($urandom_range(0, 255), $urandom_range(0, 9) != 0));
            end
          end
          if (!cut_short)
            repeat ($urandom_range(0, 2)) feed(make_item($urandom_range(0, 255), 1'b1));
        end
      end
    end

    settle();
    if (errors == 0) begin
      $display("[convolution_3x3_abs_clamp] OK");
    end else begin
      $display("[convolution_3x3_abs_clamp] ERROR");
    end
    $finish;
  end

endmodule
